// ===== hw/rtl/rgbsw_pkg.sv =====
// shared types, constants and helpers for the rgba swizzle and mask packer
package rgbsw_pkg;

  localparam int unsigned PIXEL_W       = 32;
  localparam int unsigned ROW_WIDTH_W   = 13;
  localparam int unsigned MASK_W        = 8;
  localparam int unsigned MASK_CNT_W    = 3;
  localparam int unsigned APB_DATA_W    = 32;
  localparam int unsigned APB_ADDR_W    = 3;
  localparam int unsigned MAX_ROW_WIDTH = 4096;

  localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RESET = ROW_WIDTH_W'(1);

  // bit of the alpha byte that decides opaque versus transparent
  localparam int unsigned ALPHA_KEEP_BIT = 7;

  typedef enum logic {
    REG_OPAQUE_MODE = 1'b0,
    REG_ROW_WIDTH   = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic                   opaque_mode;
    logic [ROW_WIDTH_W-1:0] row_width;
  } cfg_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] converted_pixel;
    logic               mask_byte_valid;
    logic [MASK_W-1:0]  mask_byte;
    logic               has_transparency;
    logic               image_done;
  } res_t;

  // 0xRRGGBBAA -> 0x00BBGGRR
  function automatic logic [PIXEL_W-1:0] swizzle_bgr(input logic [PIXEL_W-1:0] p);
    return {8'h00, p[15:8], p[23:16], p[31:24]};
  endfunction

endpackage

// ===== hw/rtl/rgbsw_if.sv =====
// valid/ready channel interfaces for pixel input and converted output
interface rgbsw_in_if;
  logic                          valid;
  logic                          ready;
  logic [rgbsw_pkg::PIXEL_W-1:0] pixel_word;
  logic                          last_in_image;

  modport source (output valid, output pixel_word, output last_in_image, input ready);
  modport sink   (input valid, input pixel_word, input last_in_image, output ready);
endinterface

interface rgbsw_out_if;
  logic                          valid;
  logic                          ready;
  logic [rgbsw_pkg::PIXEL_W-1:0] converted_pixel;
  logic                          mask_byte_valid;
  logic [rgbsw_pkg::MASK_W-1:0]  mask_byte;
  logic                          has_transparency;
  logic                          image_done;

  modport source (output valid, output converted_pixel, output mask_byte_valid,
                  output mask_byte, output has_transparency, output image_done,
                  input ready);
  modport sink   (input valid, input converted_pixel, input mask_byte_valid,
                  input mask_byte, input has_transparency, input image_done,
                  output ready);
endinterface

// ===== hw/rtl/rgbsw_cfg.sv =====
// apb register block: opaque mode and row width
module rgbsw_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [rgbsw_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [rgbsw_pkg::APB_DATA_W-1:0] pwdata,
  output logic [rgbsw_pkg::APB_DATA_W-1:0] prdata,
  output logic                             pready,
  output rgbsw_pkg::cfg_t                  cfg
);

  logic                                opaque_mode_r;
  logic [rgbsw_pkg::ROW_WIDTH_W-1:0]   row_width_r;
  logic                                wr_en;
  rgbsw_pkg::reg_idx_t                 reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  // registers sit on a 4-byte stride, low address bits ignored
  assign reg_sel = rgbsw_pkg::reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      opaque_mode_r <= 1'b0;
      row_width_r   <= rgbsw_pkg::ROW_WIDTH_RESET;
    end else if (wr_en) begin
      case (reg_sel)
        rgbsw_pkg::REG_OPAQUE_MODE: opaque_mode_r <= pwdata[0];
        rgbsw_pkg::REG_ROW_WIDTH:   row_width_r   <= pwdata[rgbsw_pkg::ROW_WIDTH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      rgbsw_pkg::REG_OPAQUE_MODE:
        prdata = rgbsw_pkg::APB_DATA_W'(opaque_mode_r);
      rgbsw_pkg::REG_ROW_WIDTH:
        prdata = rgbsw_pkg::APB_DATA_W'(row_width_r);
      default:
        prdata = '0;
    endcase
  end

  assign cfg.opaque_mode = opaque_mode_r;
  assign cfg.row_width   = row_width_r;

endmodule

// ===== hw/rtl/rgbsw_pack.sv =====
// per-pixel swizzle plus mask accumulator, column counter and transparency flag
module rgbsw_pack #(
  parameter int unsigned MAX_ROW_WIDTH = rgbsw_pkg::MAX_ROW_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rgbsw_pkg::cfg_t               cfg,
  input  logic                          advance,
  input  logic [rgbsw_pkg::PIXEL_W-1:0] pixel_word,
  input  logic                          last_in_image,
  output rgbsw_pkg::res_t               res
);

  localparam int unsigned CW = $clog2(MAX_ROW_WIDTH);
  localparam int unsigned WW = (CW + 1 > rgbsw_pkg::ROW_WIDTH_W) ? CW + 1
                                                                 : rgbsw_pkg::ROW_WIDTH_W;
  localparam logic [WW-1:0] MAX_W = WW'(MAX_ROW_WIDTH);

  logic [rgbsw_pkg::MASK_W-1:0]     acc_r, acc_nxt, acc_sh;
  logic [rgbsw_pkg::MASK_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [rgbsw_pkg::MASK_CNT_W:0]   cnt_inc;
  logic [CW-1:0]                    col_r, col_nxt;
  logic [CW:0]                      col_inc;
  logic                             trans_r, trans_nxt, trans_now;
  logic [WW-1:0]                    eff_w, rw_ext;
  logic                             alpha_keep, row_end;
  logic [rgbsw_pkg::PIXEL_W-1:0]    swz;

  assign swz        = rgbsw_pkg::swizzle_bgr(pixel_word);
  assign alpha_keep = pixel_word[rgbsw_pkg::ALPHA_KEEP_BIT];
  assign acc_sh     = {alpha_keep, acc_r[rgbsw_pkg::MASK_W-1:1]};
  assign cnt_inc    = {1'b0, cnt_r} + 1'b1;
  assign col_inc    = {1'b0, col_r} + 1'b1;
  assign trans_now  = trans_r | ~alpha_keep;
  assign rw_ext     = WW'(cfg.row_width);

  // zero width acts as one, oversize clamps to the maximum
  always_comb begin
    if (rw_ext == '0) begin
      eff_w = WW'(1);
    end else if (rw_ext > MAX_W) begin
      eff_w = MAX_W;
    end else begin
      eff_w = rw_ext;
    end
  end

  // a lowered width ends the row as soon as the column reaches or passes it
  assign row_end = (WW'(col_inc) >= eff_w) || last_in_image;

  always_comb begin
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    col_nxt   = col_r;
    trans_nxt = trans_r;
    res.converted_pixel  = swz;
    res.mask_byte_valid  = 1'b0;
    res.mask_byte        = '0;
    res.has_transparency = 1'b0;
    res.image_done       = last_in_image;

    if (!cfg.opaque_mode) begin
      res.converted_pixel  = alpha_keep ? {pixel_word[7:0], swz[23:0]} : '0;
      res.has_transparency = trans_now;
      trans_nxt            = trans_now;
      col_nxt              = row_end ? '0 : col_inc[CW-1:0];
      if (cnt_inc[rgbsw_pkg::MASK_CNT_W]) begin
        res.mask_byte_valid = 1'b1;
        res.mask_byte       = acc_sh;
        acc_nxt             = '0;
        cnt_nxt             = '0;
      end else if (row_end) begin
        // right-align the partial byte
        res.mask_byte_valid = 1'b1;
        res.mask_byte       = acc_sh >> (4'd8 - cnt_inc);
        acc_nxt             = '0;
        cnt_nxt             = '0;
      end else begin
        acc_nxt = acc_sh;
        cnt_nxt = cnt_inc[rgbsw_pkg::MASK_CNT_W-1:0];
      end
    end

    if (last_in_image) begin
      acc_nxt   = '0;
      cnt_nxt   = '0;
      col_nxt   = '0;
      trans_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      cnt_r   <= '0;
      col_r   <= '0;
      trans_r <= 1'b0;
    end else if (advance) begin
      acc_r   <= acc_nxt;
      cnt_r   <= cnt_nxt;
      col_r   <= col_nxt;
      trans_r <= trans_nxt;
    end
  end

endmodule

// ===== hw/rtl/rgba_pixel_swizzle_with_mask_packer_unit.sv =====
// top level: rgba to abgr pixel conversion with a packed one-bit alpha mask
//
// in_chan carries raster-order pixels 0xRRGGBBAA with a last_in_image marker;
// out_chan returns one transaction per pixel: the converted pixel, an
// optional completed mask byte (first pixel in bit 0, right-aligned at row
// end), the running transparency flag (zero in opaque mode) and an image_done echo.
// the apb port sets opaque_mode (address 0) and row_width (address 4);
// write it only while no transaction is in flight.
// a pixel accepted on in_chan passes through the input register, then the
// swizzle and mask update into the result register, from which out_chan
// offers it. throughput is one pixel per cycle while out_chan does not stall,
// set by the single mask accumulator update per cycle.
// reset clears both pipeline valid bits, the mask accumulator, bit count,
// column count and transparency flag; opaque_mode resets to 0, row_width to 1.
// when the receiver stalls, the result register holds, the input register
// fills behind it and in_chan.ready then drops until out_chan moves again.
module rgba_pixel_swizzle_with_mask_packer_unit #(
  parameter int unsigned MAX_ROW_WIDTH = rgbsw_pkg::MAX_ROW_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  rgbsw_in_if.sink                         in_chan,
  rgbsw_out_if.source                      out_chan,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [rgbsw_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [rgbsw_pkg::APB_DATA_W-1:0] pwdata,
  output logic [rgbsw_pkg::APB_DATA_W-1:0] prdata,
  output logic                             pready
);

  rgbsw_pkg::cfg_t               cfg;
  rgbsw_pkg::res_t               res;
  rgbsw_pkg::res_t               out_r;
  logic                          out_valid_r;
  logic                          s1_valid_r;
  logic [rgbsw_pkg::PIXEL_W-1:0] s1_pixel_r;
  logic                          s1_last_r;
  logic                          out_free, advance, in_take;

  rgbsw_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rgbsw_pack #(
    .MAX_ROW_WIDTH (MAX_ROW_WIDTH)
  ) u_pack (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .advance       (advance),
    .pixel_word    (s1_pixel_r),
    .last_in_image (s1_last_r),
    .res           (res)
  );

  assign out_free      = ~out_valid_r | out_chan.ready;
  assign advance       = s1_valid_r & out_free;
  assign in_chan.ready = ~s1_valid_r | out_free;
  assign in_take       = in_chan.valid & in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_chan.ready) begin
        s1_valid_r <= in_chan.valid;
      end
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_pixel_r <= in_chan.pixel_word;
      s1_last_r  <= in_chan.last_in_image;
    end
    if (advance) begin
      out_r <= res;
    end
  end

  assign out_chan.valid            = out_valid_r;
  assign out_chan.converted_pixel  = out_r.converted_pixel;
  assign out_chan.mask_byte_valid  = out_r.mask_byte_valid;
  assign out_chan.mask_byte        = out_r.mask_byte;
  assign out_chan.has_transparency = out_r.has_transparency;
  assign out_chan.image_done       = out_r.image_done;

endmodule

// ===== tb/tb.sv =====
// self-checking testbench for the rgba swizzle and alpha mask packer
`timescale 1ns / 1ps

module tb;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 60;
  localparam int SETTLE_CYCLES = 4;
  localparam int RANDOM_PIXELS = 850;

  typedef struct packed {
    logic [rgbsw_pkg::PIXEL_W-1:0] word;
    logic                          last;
  } pixel_t;

  logic clk = 1'b0;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [rgbsw_pkg::APB_ADDR_W-1:0] paddr;
  logic [rgbsw_pkg::APB_DATA_W-1:0] pwdata;
  logic [rgbsw_pkg::APB_DATA_W-1:0] prdata;
  logic pready;

  rgbsw_in_if  in_chan();
  rgbsw_out_if out_chan();

  rgba_pixel_swizzle_with_mask_packer_unit uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  pixel_t          pixel_q[$];
  rgbsw_pkg::res_t result_q[$];

  // shadow of the block's state and registers
  logic                              cur_opaque = 1'b0;
  logic [rgbsw_pkg::ROW_WIDTH_W-1:0] cur_row_width = rgbsw_pkg::ROW_WIDTH_RESET;
  logic [rgbsw_pkg::MASK_W-1:0]      pend_mask = '0;
  int                                pend_bits = 0;
  int                                col_pos = 0;
  logic                              saw_clear_alpha = 1'b0;

  int  err_count = 0;
  int  cycle_count = 0;
  int  pixels_sent = 0;
  int  images_closed = 0;
  int  mask_bytes = 0;
  bit  burst_mode = 1'b0;
  bit  hold_req = 1'b0;
  bit  hold_taken;
  int  hold_left;

  function automatic int clamp_width(input logic [rgbsw_pkg::ROW_WIDTH_W-1:0] w);
    if (w == 0) return 1;
    if (int'(w) > rgbsw_pkg::MAX_ROW_WIDTH) return rgbsw_pkg::MAX_ROW_WIDTH;
    return int'(w);
  endfunction

  function automatic rgbsw_pkg::res_t pack_pixel(input logic [rgbsw_pkg::PIXEL_W-1:0] word,
                                                 input logic last);
    rgbsw_pkg::res_t r;
    bit              row_end;
    r = '0;
    r.image_done = last;
    r.converted_pixel = {8'h00, word[15:8], word[23:16], word[31:24]};
    if (!cur_opaque) begin
      if (word[rgbsw_pkg::ALPHA_KEEP_BIT]) begin
        r.converted_pixel[31:24] = word[7:0];
        pend_mask = {1'b1, pend_mask[7:1]};
      end else begin
        r.converted_pixel = '0;
        saw_clear_alpha = 1'b1;
        pend_mask = {1'b0, pend_mask[7:1]};
      end
      pend_bits++;
      col_pos++;
      row_end = (col_pos >= clamp_width(cur_row_width)) || last;
      if (pend_bits >= 8) begin
        r.mask_byte_valid = 1'b1;
        r.mask_byte = pend_mask;
        pend_mask = '0;
        pend_bits = 0;
      end else if (row_end) begin
        // partial byte at row end goes out right-aligned
        r.mask_byte_valid = 1'b1;
        r.mask_byte = pend_mask >> (8 - pend_bits);
        pend_mask = '0;
        pend_bits = 0;
      end
      if (row_end) col_pos = 0;
      r.has_transparency = saw_clear_alpha;
    end
    if (last) begin
      pend_mask = '0;
      pend_bits = 0;
      col_pos = 0;
      saw_clear_alpha = 1'b0;
    end
    return r;
  endfunction

  always @(posedge clk) begin : pixel_driver
    bit offer;
    offer = 1'b0;
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        result_q.push_back(pack_pixel(in_chan.pixel_word, in_chan.last_in_image));
        void'(pixel_q.pop_front());
        pixels_sent++;
      end else if (in_chan.valid) begin
        offer = 1'b1;
      end
      if (!offer && pixel_q.size() > 0)
        offer = burst_mode || ($urandom_range(99) >= 8);
      in_chan.valid <= offer;
      if (offer) begin
        in_chan.pixel_word    <= pixel_q[0].word;
        in_chan.last_in_image <= pixel_q[0].last;
      end
    end
  end

  // long hold-off is counted here so the input side backs up behind it
  always @(posedge clk) begin : result_ready
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      hold_taken <= 1'b0;
      hold_left <= 0;
    end else if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_chan.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= burst_mode || ($urandom_range(99) >= 8);
    end
  end

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      err_count++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin : result_monitor
    rgbsw_pkg::res_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (result_q.size() == 0) begin
        err_count++;
        $display("%0t: unexpected transaction, expected none, got pixel %h", $time,
                 out_chan.converted_pixel);
      end else begin
        want = result_q.pop_front();
        check_field("converted_pixel", want.converted_pixel, out_chan.converted_pixel);
        check_field("mask_byte_valid", want.mask_byte_valid, out_chan.mask_byte_valid);
        check_field("mask_byte", want.mask_byte, out_chan.mask_byte);
        check_field("has_transparency", want.has_transparency, out_chan.has_transparency);
        check_field("image_done", want.image_done, out_chan.image_done);
        if (out_chan.mask_byte_valid) mask_bytes++;
        if (out_chan.image_done) images_closed++;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: run stalled, %0d results still outstanding", $time, result_q.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic write_reg(input rgbsw_pkg::reg_idx_t idx,
                           input logic [rgbsw_pkg::APB_DATA_W-1:0] value);
    logic [rgbsw_pkg::APB_DATA_W-1:0] readback;
    logic [rgbsw_pkg::APB_DATA_W-1:0] stored;
    stored = (idx == rgbsw_pkg::REG_OPAQUE_MODE) ? (value & 32'h1) : (value & 32'h1FFF);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= rgbsw_pkg::APB_ADDR_W'(4 * int'(idx));
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    if (idx == rgbsw_pkg::REG_OPAQUE_MODE) cur_opaque = value[0];
    else cur_row_width = value[rgbsw_pkg::ROW_WIDTH_W-1:0];
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    readback = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (readback !== stored) begin
      err_count++;
      $display("%0t: %s read back, expected %h, got %h", $time, idx.name(), stored, readback);
    end
  endtask

  function automatic void queue_pixel(input logic [rgbsw_pkg::PIXEL_W-1:0] word,
                                      input logic last);
    pixel_t p;
    p.word = word;
    p.last = last;
    pixel_q.push_back(p);
  endfunction

  function automatic logic [rgbsw_pkg::PIXEL_W-1:0] rand_pixel(input int bias);
    logic [rgbsw_pkg::PIXEL_W-1:0] w;
    w = $urandom();
    if (bias == 1) w[rgbsw_pkg::ALPHA_KEEP_BIT] = 1'b1;
    else if (bias == 2) w[rgbsw_pkg::ALPHA_KEEP_BIT] = 1'b0;
    return w;
  endfunction

  task automatic wait_drained();
    do @(posedge clk);
    while (pixel_q.size() != 0 || in_chan.valid || result_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    int phase_no;
    int settings;
    int rand_pixels;
    int n_img;
    int total;
    int len;
    int kind;
    int bias;
    int eff;
    logic [rgbsw_pkg::ROW_WIDTH_W-1:0] new_width;

    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_chan.valid = 1'b0;
    in_chan.pixel_word = '0;
    in_chan.last_in_image = 1'b0;
    out_chan.ready = 1'b0;
    settings = 0;
    rand_pixels = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // full byte landing exactly on row end, then an image ending mid-row
    write_reg(rgbsw_pkg::REG_OPAQUE_MODE, 32'd0);
    write_reg(rgbsw_pkg::REG_ROW_WIDTH, 32'd8);
    settings++;
    @(negedge clk);
    queue_pixel(32'hFFFF_FFFF, 1'b0);
    queue_pixel(32'h0000_0000, 1'b0);
    queue_pixel(32'h1234_5680, 1'b0);
    queue_pixel(32'hABCD_EF7F, 1'b0);
    queue_pixel(32'h0000_00FF, 1'b0);
    queue_pixel(32'hFFFF_FF00, 1'b0);
    queue_pixel(32'h89AB_CD80, 1'b0);
    queue_pixel(32'h7654_3201, 1'b0);
    queue_pixel(32'hDEAD_BEEF, 1'b0);
    queue_pixel(32'hCAFE_0080, 1'b1);
    wait_drained();

    // zero width behaves as one pixel per row
    write_reg(rgbsw_pkg::REG_ROW_WIDTH, 32'd0);
    settings++;
    @(negedge clk);
    queue_pixel(32'h1122_3380, 1'b0);
    queue_pixel(32'h4455_6600, 1'b1);
    wait_drained();

    // width beyond the maximum is clamped
    write_reg(rgbsw_pkg::REG_ROW_WIDTH, 32'h0000_1FFF);
    settings++;
    @(negedge clk);
    queue_pixel(32'h0F0F_0FF0, 1'b0);
    queue_pixel(32'hF0F0_F00F, 1'b1);
    wait_drained();

    // colour-only pixels, then the same image carries on masked
    write_reg(rgbsw_pkg::REG_OPAQUE_MODE, 32'd1);
    settings++;
    @(negedge clk);
    queue_pixel(32'hFFFF_FFFF, 1'b0);
    queue_pixel(32'h0000_0000, 1'b0);
    wait_drained();
    write_reg(rgbsw_pkg::REG_OPAQUE_MODE, 32'd0);
    write_reg(rgbsw_pkg::REG_ROW_WIDTH, 32'd12);
    settings++;
    @(negedge clk);
    queue_pixel(32'h0102_0380, 1'b0);
    queue_pixel(32'h0405_0600, 1'b0);
    queue_pixel(32'h0708_09FF, 1'b0);
    queue_pixel(32'h0A0B_0C7F, 1'b0);
    queue_pixel(32'h0D0E_0F80, 1'b0);
    queue_pixel(32'h1011_1200, 1'b0);
    wait_drained();

    // narrowing the row mid-row ends it at the next pixel
    write_reg(rgbsw_pkg::REG_ROW_WIDTH, 32'd3);
    settings++;
    @(negedge clk);
    queue_pixel(32'h1314_1580, 1'b0);
    queue_pixel(32'h1617_1801, 1'b1);
    wait_drained();

    // receiver holds off while the sender keeps offering
    write_reg(rgbsw_pkg::REG_ROW_WIDTH, 32'd16);
    settings++;
    @(negedge clk);
    hold_req = 1'b1;
    for (int i = 0; i < 48; i++) queue_pixel(rand_pixel(0), i == 47);
    wait_drained();

    phase_no = 0;
    while (rand_pixels < RANDOM_PIXELS) begin
      write_reg(rgbsw_pkg::REG_OPAQUE_MODE, ($urandom_range(4) == 0) ? 32'd1 : 32'd0);
      case ($urandom_range(13))
        0:       new_width = 13'd1;
        1:       new_width = 13'd2;
        2:       new_width = 13'd3;
        3:       new_width = 13'd7;
        4:       new_width = 13'd8;
        5:       new_width = 13'd9;
        6:       new_width = 13'd16;
        7:       new_width = 13'd0;
        8:       new_width = 13'h1FFF;
        9:       new_width = 13'd4096;
        10:      new_width = 13'($urandom_range(4097, 8190));
        default: new_width = 13'($urandom_range(1, 40));
      endcase
      write_reg(rgbsw_pkg::REG_ROW_WIDTH, 32'(new_width));
      settings++;
      eff = clamp_width(new_width);
      @(negedge clk);
      // a run of phases with neither side idling
      burst_mode = (phase_no >= 4 && phase_no < 8);
      n_img = $urandom_range(1, 4);
      for (int m = 0; m < n_img; m++) begin
        total = (eff <= 40) ? $urandom_range(1, 3) * eff : $urandom_range(1, 60);
        kind = $urandom_range(9);
        bias = $urandom_range(5);
        len = (kind == 8) ? $urandom_range(1, total) : total;
        for (int i = 0; i < len; i++)
          queue_pixel(rand_pixel(bias > 2 ? 0 : bias), (i == len - 1) && (kind != 9));
        rand_pixels += len;
      end
      wait_drained();
      phase_no++;
    end

    $display("checked %0d pixels under %0d register settings", pixels_sent, settings);
    $display("%0d images closed, %0d mask bytes compared", images_closed, mask_bytes);
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/rgbsw_pkg.sv
hw/rtl/rgbsw_if.sv
hw/rtl/rgbsw_cfg.sv
hw/rtl/rgbsw_pack.sv
hw/rtl/rgba_pixel_swizzle_with_mask_packer_unit.sv
tb/tb.sv
